// File: rtl/pbl_pkg.sv
// ----------------------------------------------------------------------------
// pbl_pkg
// Shared types and constants of the power button long-press detector.
// ----------------------------------------------------------------------------
package pbl_pkg;

	// Defaults of the top-level parameters
	localparam int DEBOUNCE_TICKS_DEF = 2;
	localparam int COUNT_WIDTH_DEF    = 16;

	// Configuration port
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH  = 16;
	localparam int HOLD_WIDTH      = 16;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLD_TICKS    = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_ESCAPE_ENABLE = 2'd1;

	// Reported state codes
	localparam logic [1:0] MS_IDLE     = 2'd0;
	localparam logic [1:0] MS_DEBOUNCE = 2'd1;
	localparam logic [1:0] MS_DOWN     = 2'd2;
	localparam logic [1:0] MS_HOLD     = 2'd3;

	// Internal phase, one-hot
	typedef enum logic [3:0] {
		PH_IDLE     = 4'b0001,
		PH_DEBOUNCE = 4'b0010,
		PH_DOWN     = 4'b0100,
		PH_HOLD     = 4'b1000
	} phase_t;

	// Configuration as seen by the state machine
	typedef struct packed {
		logic [HOLD_WIDTH-1:0] hold_ticks;
		logic                  escape_enable;
	} cfg_t;

	// One result transaction
	typedef struct packed {
		logic       power_pulse;
		logic       escape_pulse;
		logic       backlight_off;
		logic [1:0] machine_state;
	} result_t;

	// Map a one-hot phase onto its reported code
	function automatic logic [1:0] phase_code(phase_t ph);
		logic [1:0] code;
		unique case (ph)
			PH_IDLE:     code = MS_IDLE;
			PH_DEBOUNCE: code = MS_DEBOUNCE;
			PH_DOWN:     code = MS_DOWN;
			PH_HOLD:     code = MS_HOLD;
			default:     code = MS_IDLE;
		endcase
		return code;
	endfunction

endpackage

// File: rtl/power_button_long_press.sv
// ----------------------------------------------------------------------------
// power_button_long_press
// Power button long-press detector, one sampled button level per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one button_level sample per
//   transaction. Output channel (out_valid/out_stall) returns exactly one
//   result per sample: power_pulse, escape_pulse, backlight_off and the
//   machine_state reached after that sample.
//   The result of an accepted sample is registered. Throughput is one sample
//   per cycle while in_stall is low; the state update is a single pass of
//   logic ahead of the result register.
//   When the receiver stalls, one further sample is taken into a skid entry,
//   then in_stall rises until the result register drains.
//   Configuration (cfg_we/cfg_index/cfg_data) writes hold_ticks (index 0)
//   and escape_enable (index 1); other indexes are ignored. Write only while
//   the block is idle.
//   Reset clears both registers to zero, returns the machine to idle with
//   the button taken as released, and empties the output stage.
// ----------------------------------------------------------------------------
module power_button_long_press #(
	parameter int DEBOUNCE_TICKS = pbl_pkg::DEBOUNCE_TICKS_DEF,
	parameter int COUNT_WIDTH    = pbl_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pbl_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [pbl_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 button_level,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 power_pulse,
	output logic                                 escape_pulse,
	output logic                                 backlight_off,
	output logic [1:0]                           machine_state
);

	pbl_pkg::cfg_t     cfg_q;
	pbl_pkg::result_t  fsm_res, out_res;
	logic              advance;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_ticks    <= '0;
			cfg_q.escape_enable <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == pbl_pkg::REG_HOLD_TICKS) begin
				cfg_q.hold_ticks <= cfg_data[pbl_pkg::HOLD_WIDTH-1:0];
			end else if (cfg_index == pbl_pkg::REG_ESCAPE_ENABLE) begin
				cfg_q.escape_enable <= cfg_data[0];
			end
		end
	end

	assign advance = in_valid && !in_stall;

	pbl_fsm #(
		.DEBOUNCE_TICKS (DEBOUNCE_TICKS),
		.COUNT_WIDTH    (COUNT_WIDTH)
	) u_fsm (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.button_level (button_level),
		.cfg          (cfg_q),
		.res          (fsm_res)
	);

	pbl_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (fsm_res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign power_pulse   = out_res.power_pulse;
	assign escape_pulse  = out_res.escape_pulse;
	assign backlight_off = out_res.backlight_off;
	assign machine_state = out_res.machine_state;

`ifndef SYNTHESIS
	// A skid entry is only ever filled behind a full result register
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("skid entry occupied with empty result register");

	// Power pulse always comes with backlight-off and lands in the hold state
	a_power_with_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && power_pulse) |->
		(backlight_off && machine_state == pbl_pkg::MS_HOLD))
		else $error("power pulse without backlight-off or hold state");

	// Escape pulse only on the release that returns to idle
	a_escape_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && escape_pulse) |->
		(machine_state == pbl_pkg::MS_IDLE && !power_pulse))
		else $error("escape pulse outside a return to idle");
`endif

endmodule

// File: rtl/pbl_fsm.sv
// ----------------------------------------------------------------------------
// pbl_fsm
// Press state machine: debounce, hold timeout and pulse generation. Advances
// by one sample on each accepted input transaction.
// ----------------------------------------------------------------------------
module pbl_fsm #(
	parameter int DEBOUNCE_TICKS = pbl_pkg::DEBOUNCE_TICKS_DEF,
	parameter int COUNT_WIDTH    = pbl_pkg::COUNT_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              button_level,
	input  pbl_pkg::cfg_t     cfg,
	output pbl_pkg::result_t  res
);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX      = {COUNT_WIDTH{1'b1}};
	localparam logic [COUNT_WIDTH-1:0] DEBOUNCE_CNT = COUNT_WIDTH'(DEBOUNCE_TICKS);

	pbl_pkg::phase_t         phase_q, phase_d;
	logic [COUNT_WIDTH-1:0]  cnt_q, cnt_d;
	logic                    last_q;
	logic [COUNT_WIDTH-1:0]  hold_sat;
	logic [COUNT_WIDTH-1:0]  cnt_dec;

	// Saturate the hold timeout to the counter range
	generate
		if (COUNT_WIDTH >= pbl_pkg::HOLD_WIDTH) begin : g_hold_wide
			assign hold_sat = COUNT_WIDTH'(cfg.hold_ticks);
		end else begin : g_hold_narrow
			assign hold_sat = (cfg.hold_ticks > pbl_pkg::HOLD_WIDTH'(CNT_MAX)) ?
				CNT_MAX : cfg.hold_ticks[COUNT_WIDTH-1:0];
		end
	endgenerate

	// Decrement that stops at zero
	assign cnt_dec = (cnt_q != '0) ? cnt_q - 1'b1 : '0;

	// Next state and pulses for this sample
	always_comb begin
		phase_d           = phase_q;
		cnt_d             = cnt_q;
		res.power_pulse   = 1'b0;
		res.escape_pulse  = 1'b0;
		res.backlight_off = 1'b0;
		unique case (phase_q)
			pbl_pkg::PH_IDLE: begin
				if (button_level && !last_q) begin
					phase_d = pbl_pkg::PH_DEBOUNCE;
					cnt_d   = DEBOUNCE_CNT;
				end
			end
			pbl_pkg::PH_DEBOUNCE: begin
				cnt_d = cnt_dec;
				if (cnt_dec == '0) begin
					if (button_level) begin
						phase_d = pbl_pkg::PH_DOWN;
						cnt_d   = hold_sat;
					end else begin
						phase_d = pbl_pkg::PH_IDLE;
					end
				end
			end
			pbl_pkg::PH_DOWN: begin
				if (!button_level) begin
					phase_d          = pbl_pkg::PH_IDLE;
					res.escape_pulse = cfg.escape_enable;
				end else if (cnt_q == '0) begin
					phase_d           = pbl_pkg::PH_HOLD;
					res.power_pulse   = 1'b1;
					res.backlight_off = 1'b1;
				end else begin
					cnt_d = cnt_dec;
				end
			end
			pbl_pkg::PH_HOLD: begin
				if (!button_level) begin
					phase_d = pbl_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_d = pbl_pkg::PH_IDLE;
			end
		endcase
		res.machine_state = pbl_pkg::phase_code(phase_d);
	end

	// Advance the state on each accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pbl_pkg::PH_IDLE;
			cnt_q   <= '0;
			last_q  <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			last_q  <= button_level;
		end
	end

endmodule

// File: rtl/pbl_skid.sv
// ----------------------------------------------------------------------------
// pbl_skid
// Result register with a skid entry, so the input side can take one further
// transaction after the receiver starts to stall.
// ----------------------------------------------------------------------------
module pbl_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  pbl_pkg::result_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output pbl_pkg::result_t  out_data
);

	logic              main_valid_q, skid_valid_q;
	pbl_pkg::result_t  main_q, skid_q;
	logic              take, drain;

	assign in_stall  = skid_valid_q;
	assign take      = in_valid && !skid_valid_q;
	assign drain     = main_valid_q && !out_stall;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	// Track occupancy of both entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (drain || !main_valid_q) begin
				main_valid_q <= skid_valid_q || take;
				skid_valid_q <= 1'b0;
			end else if (take) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Move payload: refill from skid first, park in skid when stalled
	always_ff @(posedge clk) begin
		if (drain || !main_valid_q) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (take) begin
				main_q <= in_data;
			end
		end else if (take) begin
			skid_q <= in_data;
		end
	end

endmodule
